FILE: design/pfts_pkg.sv
// Package for the PES frame type and size scanner.
// Holds scan phase and frame type enums, stream ids and size constants.
// No dependencies; imported by every module of the block.
package pfts_pkg;

    // Widths of the stream fields
    localparam int BYTE_W   = 8;
    localparam int SIZE_W   = 31;
    localparam int WINDOW_W = 24;
    localparam int LEN_W    = 16;

    // APB register map: one 32-bit register per word
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    // Register indexes (paddr word index)
    localparam logic REG_START_CODE = 1'b0;

    // Reset value of the start code register
    localparam logic [WINDOW_W-1:0] START_CODE_RST = 24'h00_0001;

    // Smallest amount of data worth a search
    localparam logic [SIZE_W-1:0] MIN_WINDOW = 31'd1024;

    // Stream ids and video length threshold
    localparam logic [BYTE_W-1:0] VIDEO_ID   = 8'hE0;
    localparam logic [BYTE_W-1:0] AUDIO_ID   = 8'hC0;
    localparam logic [LEN_W-1:0]  LONG_VIDEO = 16'd1024;

    localparam logic [SIZE_W-1:0] SIZE_MAX = {SIZE_W{1'b1}};

    // Scan phase
    typedef enum logic [2:0] {
        PH_START  = 3'd0,
        PH_SECOND = 3'd1,
        PH_THIRD  = 3'd2,
        PH_SCAN   = 3'd3,
        PH_LEN_HI = 3'd4,
        PH_LEN_LO = 3'd5
    } t_phase;

    // Result frame type
    typedef enum logic [1:0] {
        FT_UNKNOWN = 2'd0,
        FT_VIDEO   = 2'd1,
        FT_AUDIO   = 2'd2
    } t_frame_type;

endpackage

FILE: design/pes_frame_type_and_size_scanner.sv
// Result words are registered: one appears in the cycle after its closing byte.
// Throughput: one byte per cycle; the input stalls only while a result is held
// in the output register and the downstream side stalls.
// The per-byte path is one 33-bit add and compare for the capped size.
// Reset (synchronous, active low) clears the scan state to start of search and the
// start code register to 1.
module pes_frame_type_and_size_scanner
    import pfts_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    // byte stream in
    input  logic                    i_in_valid,
    output logic                    o_in_stall,
    input  logic [BYTE_W-1:0]       i_byte_value,
    input  logic [SIZE_W-1:0]       i_data_left,
    input  logic                    i_last,
    // result out
    output logic                    o_out_valid,
    input  logic                    i_out_stall,
    output logic [1:0]              o_frame_type,
    output logic [SIZE_W-1:0]       o_frame_size,
    // configuration
    input  logic                    psel,
    input  logic                    penable,
    input  logic                    pwrite,
    input  logic [APB_ADDR_W-1:0]   paddr,
    input  logic [APB_DATA_W-1:0]   pwdata,
    output logic [APB_DATA_W-1:0]   prdata,
    output logic                    pready
);

    logic [WINDOW_W-1:0] w_start_code;

    pfts_regs u_regs (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .o_start_code (w_start_code)
    );

    // scan state
    t_phase              r_phase,   n_phase;
    logic [WINDOW_W-1:0] r_window,  n_window;
    logic [SIZE_W-1:0]   r_count,   n_count;
    logic [SIZE_W-1:0]   r_limit,   n_limit;
    logic [BYTE_W-1:0]   r_len_hi,  n_len_hi;
    logic                r_audio,   n_audio;

    // output register
    logic                r_out_valid;
    t_frame_type         r_out_type;
    logic [SIZE_W-1:0]   r_out_size;

    // per-byte result
    logic                w_res_valid;
    t_frame_type         w_res_type;
    logic [SIZE_W-1:0]   w_res_size;

    logic                w_in_accept;
    logic                w_short;
    logic                w_id_hit;
    logic                w_found;
    logic                w_cnt_sat;
    logic [SIZE_W-1:0]   w_count_inc;
    logic [LEN_W-1:0]    w_len;
    logic [SIZE_W+1:0]   w_total;
    logic [SIZE_W-1:0]   w_capped;
    logic [WINDOW_W-1:0] w_shifted;

    assign o_in_stall  = r_out_valid && i_out_stall;
    assign w_in_accept = i_in_valid && !o_in_stall;

    // shared decode of the current byte
    assign w_short     = (r_phase == PH_START) && (i_data_left < MIN_WINDOW);
    assign w_id_hit    = (r_window == w_start_code) &&
                         ((i_byte_value == VIDEO_ID) || (i_byte_value == AUDIO_ID));
    assign w_len       = {r_len_hi, i_byte_value};
    assign w_found     = (r_phase == PH_LEN_LO) && (r_audio || (w_len > LONG_VIDEO));
    assign w_shifted   = {r_window[WINDOW_W-BYTE_W-1:0], i_byte_value};

    // saturating byte count; the capped size folds the increment in as carry
    assign w_cnt_sat   = (r_count == SIZE_MAX);
    assign w_count_inc = w_cnt_sat ? r_count : r_count + 1'b1;
    assign w_total     = {2'b00, r_count} + {{(SIZE_W+2-LEN_W){1'b0}}, w_len}
                       + {{(SIZE_W+1){1'b0}}, !w_cnt_sat};
    assign w_capped    = (w_total > {2'b00, r_limit}) ? r_limit : w_total[SIZE_W-1:0];

    // next phase
    always_comb begin
        n_phase = r_phase;
        unique case (r_phase)
            PH_START:  n_phase = w_short ? PH_START : PH_SECOND;
            PH_SECOND: n_phase = PH_THIRD;
            PH_THIRD:  n_phase = PH_SCAN;
            PH_SCAN:   n_phase = w_id_hit ? PH_LEN_HI : PH_SCAN;
            PH_LEN_HI: n_phase = PH_LEN_LO;
            PH_LEN_LO: n_phase = w_found ? PH_START : PH_SCAN;
            default:   n_phase = PH_START;
        endcase
        // a marked last byte always ends the search
        if (i_last) begin
            n_phase = PH_START;
        end
    end

    // datapath and result
    always_comb begin
        n_window    = r_window;
        n_count     = w_count_inc;
        n_limit     = r_limit;
        n_len_hi    = r_len_hi;
        n_audio     = r_audio;
        w_res_valid = 1'b0;
        w_res_type  = FT_UNKNOWN;
        w_res_size  = '0;
        unique case (r_phase)
            PH_START: begin
                n_limit  = i_data_left;
                n_count  = {{(SIZE_W-1){1'b0}}, 1'b1};
                n_window = {{(WINDOW_W-BYTE_W){1'b0}}, i_byte_value};
                n_audio  = 1'b0;
                n_len_hi = '0;
            end
            PH_SECOND, PH_THIRD: begin
                n_window = w_shifted;
            end
            PH_SCAN: begin
                if (w_id_hit) begin
                    n_audio = (i_byte_value == AUDIO_ID);
                end else begin
                    n_window = w_shifted;
                end
            end
            PH_LEN_HI: begin
                n_len_hi = i_byte_value;
            end
            PH_LEN_LO: begin
                if (w_found) begin
                    w_res_type = r_audio ? FT_AUDIO : FT_VIDEO;
                    w_res_size = w_capped;
                end else begin
                    n_window = w_shifted;
                end
            end
            default: begin
                n_count = r_count;
            end
        endcase
        // short data gives unknown; otherwise a find or the last byte closes the search
        if (w_short) begin
            w_res_valid = 1'b1;
            w_res_type  = FT_UNKNOWN;
            w_res_size  = '0;
        end else if (w_found || i_last) begin
            w_res_valid = 1'b1;
        end
    end

    // scan state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_START;
            r_window <= '0;
            r_count  <= '0;
            r_limit  <= '0;
            r_len_hi <= '0;
            r_audio  <= 1'b0;
        end else if (w_in_accept) begin
            r_phase  <= n_phase;
            r_window <= n_window;
            r_count  <= n_count;
            r_limit  <= n_limit;
            r_len_hi <= n_len_hi;
            r_audio  <= n_audio;
        end
    end

    // output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_in_accept && w_res_valid) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // output word
    always_ff @(posedge i_clk) begin
        if (w_in_accept && w_res_valid) begin
            r_out_type <= w_res_type;
            r_out_size <= w_res_size;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_frame_type = r_out_type;
    assign o_frame_size = r_out_size;

    // an unknown result never carries a size
    a_unknown_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_frame_type == FT_UNKNOWN)) |-> (o_frame_size == '0))
        else $error("unknown result with nonzero size");

    // a new output word only follows an accepted byte
    a_out_from_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(w_in_accept))
        else $error("output word without accepted byte");

    // a result always returns the scanner to start of search
    a_result_restarts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_accept && w_res_valid) |=> (r_phase == PH_START))
        else $error("search continued after a result");

    // inside a search at least one byte has been counted
    a_count_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase != PH_START) |-> (r_count != '0))
        else $error("byte count zero inside a search");

endmodule

FILE: design/pfts_regs.sv
// APB register file of the PES frame type and size scanner.
// Holds the start code register; depends on pfts_pkg.
module pfts_regs
    import pfts_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    psel,
    input  logic                    penable,
    input  logic                    pwrite,
    input  logic [APB_ADDR_W-1:0]   paddr,
    input  logic [APB_DATA_W-1:0]   pwdata,
    output logic [APB_DATA_W-1:0]   prdata,
    output logic                    pready,
    output logic [WINDOW_W-1:0]     o_start_code
);

    logic [WINDOW_W-1:0] r_start_code;
    logic                w_reg_idx;
    logic                w_wr;

    // word index of the access
    assign w_reg_idx = paddr[APB_ADDR_W-1];
    assign w_wr      = psel && penable && pwrite;
    assign pready    = 1'b1;

    // register write, taken in the access phase
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_code <= START_CODE_RST;
        end else if (w_wr && (w_reg_idx == REG_START_CODE)) begin
            r_start_code <= pwdata[WINDOW_W-1:0];
        end
    end

    // read mux
    always_comb begin
        unique case (w_reg_idx)
            REG_START_CODE: prdata = {{(APB_DATA_W-WINDOW_W){1'b0}}, r_start_code};
            default:        prdata = '0;
        endcase
    end

    assign o_start_code = r_start_code;

endmodule
